### rtl/core/pps_pkg.sv
// Shared constants and types for the population step block.
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

  localparam int unsigned AGENT_SLOTS = 1024;
  localparam int unsigned GENE_BITS   = 32;

  localparam int unsigned SLOT_W = $clog2(AGENT_SLOTS);
  localparam int unsigned POP_W  = $clog2(AGENT_SLOTS + 1);
  localparam int unsigned GIDX_W = $clog2(GENE_BITS);

  // fixed field widths
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DRAW_W  = 16;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned OPOP_W  = 11;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CFGI_W  = 2;
  localparam int unsigned MODE_W  = 2;

  // crowding compare: draw * AGENT_SLOTS <= living * 2^DRAW_W
  localparam int unsigned CMP_W = DRAW_W + POP_W + 1;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_AGE   = 2'd1,
    MODE_REPRO = 2'd2,
    MODE_NOP   = 2'd3
  } pps_mode_e;

  typedef enum logic [CFGI_W-1:0] {
    CFG_BAD_LIMIT = 2'd0,
    CFG_REPRO_AGE = 2'd1,
    CFG_SPARE2    = 2'd2,
    CFG_SPARE3    = 2'd3
  } pps_cfg_e;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic                 alive;
    logic [CNT_W-1:0]     bad;
    logic [CNT_W-1:0]     age;
    logic [GENE_BITS-1:0] gene;
  } pps_entry_t;

  localparam int unsigned ENTRY_W = $bits(pps_entry_t);

  // input item, last field lowest
  typedef struct packed {
    logic [WORD_W-1:0] mutation_mask;
    logic [DRAW_W-1:0] death_draw;
    logic              load_alive;
    logic [WORD_W-1:0] gene_word;
    logic [IDX_W-1:0]  agent_index;
  } pps_item_t;

  // result item, last field lowest
  typedef struct packed {
    logic [OPOP_W-1:0] population;
    logic              table_full;
    logic [IDX_W-1:0]  child_index;
    logic              child_made;
    logic              died;
    logic [CNT_W-1:0]  bad_gene_count;
    logic [CNT_W-1:0]  agent_age;
    logic              agent_alive;
  } pps_result_t;

  localparam int unsigned ITEM_W = $bits(pps_item_t);
  localparam int unsigned RES_W  = $bits(pps_result_t);

endpackage
`default_nettype wire

### rtl/core/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/penna_population_step_top.sv
// Top level: agent table and step sequencer for the asexual Penna aging model.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input stream (s_axis_*): one transaction is one step. tuser carries the mode
//   (load, age, reproduce, no-op); tdata carries index, genes, alive flag, the
//   crowding draw and the mutation mask. Output stream (m_axis_*): one result
//   transaction per step with the addressed agent, death/child/full flags and
//   the population after the step.
//   Config channel (cfg_*): always ready; index 0 = bad gene limit, index 1 =
//   reproduction age. Write only while no step is in flight.
// Step sequence
//   Every agent lives in one RAM word (genes, age, bad count, alive mark), one
//   read and one write port, read data registered. Load, age and no-op steps
//   pass through RAM read in the accept cycle, evaluate/write back and result
//   handoff into the output register. Reproduce adds, for an eligible parent,
//   a free-slot scan from the rotating pointer, each slot read then checked,
//   visiting up to AGENT_SLOTS slots on a full table. One step in flight;
//   tready high only when idle.
// Reset and stalls
//   After reset a clearing pass writes every slot dead, one slot a cycle;
//   s_axis_tready stays low meanwhile.
//   The result sits in an output register; a new step is accepted while it
//   waits, and that step waits at its handoff until the register is taken.
module penna_population_step_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // slave stream, tdata from bit 0: agent_index[9:0], gene_word[31:0],
  // load_alive, death_draw[15:0], mutation_mask[31:0], zero fill
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [pps_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: mode[1:0]
  input  wire logic [pps_pkg::MODE_W-1:0]      s_axis_tuser_i,
  // master stream, tdata from bit 0: agent_alive, agent_age[5:0],
  // bad_gene_count[5:0], died, child_made, child_index[9:0], table_full,
  // population[10:0], zero fill
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [pps_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [pps_pkg::CFGI_W-1:0]      cfg_index_i,
  input  wire logic [pps_pkg::CFG_W-1:0]       cfg_data_i
);
  import pps_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [SLOT_W-1:0]     clr_q;
  pps_item_t             item_q;
  pps_mode_e             mode_q;
  logic [CFG_W-1:0]      bad_limit_q;
  logic [CFG_W-1:0]      repro_age_q;
  logic [POP_W-1:0]      living_q;
  logic [SLOT_W-1:0]     free_ptr_q;
  logic [SLOT_W-1:0]     scan_ptr_q;
  logic [SLOT_W:0]       scan_cnt_q;
  logic [GENE_BITS-1:0]  par_gene_q;
  pps_result_t           res_q;
  pps_result_t           out_q;
  logic                  out_valid_q;

  // RAM port signals
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  pps_entry_t            ram_wdata;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  pps_entry_t            ent;

  logic [SLOT_W-1:0]     in_slot;
  logic [SLOT_W-1:0]     a_slot;
  logic [SLOT_W-1:0]     scan_next;
  logic                  gene_bad;
  logic [CNT_W-1:0]      new_bad;
  logic [CNT_W-1:0]      new_age;
  logic [CMP_W-1:0]      draw_lhs;
  logic [CMP_W-1:0]      pop_rhs;
  logic                  dies;
  logic                  eligible;
  logic                  s_accept;
  logic                  handoff;
  pps_result_t           eval_res;
  pps_result_t           hand_res;

  pps_item_t             in_item;

  assign in_item   = pps_item_t'(s_axis_tdata_i[ITEM_W-1:0]);
  assign in_slot   = SLOT_W'(in_item.agent_index);
  assign a_slot    = SLOT_W'(item_q.agent_index);
  assign ent       = pps_entry_t'(ram_rdata);
  assign scan_next = (scan_ptr_q == SLOT_W'(AGENT_SLOTS - 1)) ? '0 : scan_ptr_q + 1'b1;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_q);
  assign handoff         = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // aging arithmetic on the entry just read
  always_comb begin
    gene_bad = 1'b0;
    if ({1'b0, ent.age} < (CNT_W + 1)'(GENE_BITS)) begin
      gene_bad = ent.gene[ent.age[GIDX_W-1:0]];
    end
    new_bad  = (gene_bad && ent.bad != CNT_MAX) ? ent.bad + 1'b1 : ent.bad;
    new_age  = (ent.age != CNT_MAX) ? ent.age + 1'b1 : ent.age;
    draw_lhs = CMP_W'(item_q.death_draw) * CMP_W'(AGENT_SLOTS);
    pop_rhs  = CMP_W'(living_q) << DRAW_W;
    dies     = ({1'b0, new_bad} >= {1'b0, bad_limit_q})
            || ({1'b0, new_age} >= (CNT_W + 1)'(GENE_BITS))
            || (draw_lhs <= pop_rhs);
    eligible = ent.alive && ({1'b0, ent.age} >= {1'b0, repro_age_q});
  end

  // report of the addressed agent after the evaluate cycle
  always_comb begin
    eval_res                = '0;
    eval_res.agent_alive    = ent.alive;
    eval_res.agent_age      = ent.age;
    eval_res.bad_gene_count = ent.bad;
    case (mode_q)
      MODE_LOAD: begin
        eval_res.agent_alive    = item_q.load_alive;
        eval_res.agent_age      = '0;
        eval_res.bad_gene_count = '0;
      end
      MODE_AGE: begin
        if (ent.alive) begin
          eval_res.agent_alive    = !dies;
          eval_res.agent_age      = new_age;
          eval_res.bad_gene_count = new_bad;
          eval_res.died           = dies;
        end
      end
      default: begin
      end
    endcase
  end

  // result with the population after the step
  always_comb begin
    hand_res            = res_q;
    hand_res.population = OPOP_W'(living_q);
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_slot;
    ram_wdata = ent;
    ram_re    = 1'b0;
    ram_raddr = in_slot;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_re = s_accept;
      end
      ST_EVAL: begin
        case (mode_q)
          MODE_LOAD: begin
            ram_we         = 1'b1;
            ram_wdata      = '0;
            ram_wdata.gene = GENE_BITS'(item_q.gene_word);
            ram_wdata.alive = item_q.load_alive;
          end
          MODE_AGE: begin
            ram_we        = ent.alive;
            ram_wdata.bad = new_bad;
            ram_wdata.age = new_age;
            ram_wdata.alive = !dies;
          end
          default: begin
          end
        endcase
      end
      ST_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = scan_ptr_q;
      end
      ST_SCAN_CHK: begin
        ram_we          = !ent.alive;
        ram_waddr       = scan_ptr_q;
        ram_wdata       = '0;
        ram_wdata.alive = 1'b1;
        ram_wdata.gene  = par_gene_q ^ GENE_BITS'(item_q.mutation_mask);
      end
      default: begin
      end
    endcase
  end

  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (AGENT_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer, counters and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      bad_limit_q <= CFG_W'(3);
      repro_age_q <= CFG_W'(6);
      living_q    <= '0;
      free_ptr_q  <= '0;
      scan_ptr_q  <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_NOP;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (pps_cfg_e'(cfg_index_i))
          CFG_BAD_LIMIT: bad_limit_q <= cfg_data_i;
          CFG_REPRO_AGE: repro_age_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // taken with no new result behind it
      if (out_valid_q && m_axis_tready_i && !handoff) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SLOT_W'(AGENT_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            item_q  <= in_item;
            mode_q  <= pps_mode_e'(s_axis_tuser_i);
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          res_q   <= eval_res;
          state_q <= (mode_q == MODE_REPRO && eligible) ? ST_SCAN_RD : ST_DONE;
          case (mode_q)
            MODE_LOAD: begin
              if (ent.alive && !item_q.load_alive && living_q != '0) begin
                living_q <= living_q - 1'b1;
              end else if (!ent.alive && item_q.load_alive) begin
                living_q <= living_q + 1'b1;
              end
            end
            MODE_AGE: begin
              if (ent.alive && dies && living_q != '0) begin
                living_q <= living_q - 1'b1;
              end
            end
            MODE_REPRO: begin
              if (eligible) begin
                par_gene_q <= ent.gene;
                scan_ptr_q <= free_ptr_q;
                scan_cnt_q <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN_RD: begin
          state_q <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (!ent.alive) begin
            res_q.child_made  <= 1'b1;
            res_q.child_index <= IDX_W'(scan_ptr_q);
            living_q          <= living_q + 1'b1;
            free_ptr_q        <= scan_next;
            state_q           <= ST_DONE;
          end else if (scan_cnt_q == (SLOT_W + 1)'(AGENT_SLOTS - 1)) begin
            res_q.table_full <= 1'b1;
            state_q          <= ST_DONE;
          end else begin
            scan_ptr_q <= scan_next;
            scan_cnt_q <= scan_cnt_q + 1'b1;
            state_q    <= ST_SCAN_RD;
          end
        end
        ST_DONE: begin
          if (handoff) begin
            out_q       <= hand_res;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
